/* hdl/sedd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serpentine error-diffusion dither package
// Shared constants, register map and the error share function.
// ----------------------------------------------------------------------------
package sedd_pkg;

   localparam int MAX_WIDTH_DEF  = 512;
   localparam int VALUE_BITS_DEF = 12;
   localparam int OUT_BYTES_MAX  = 64;
   localparam int OB_ADDR_BITS   = $clog2(OUT_BYTES_MAX);

   localparam logic [2:0] REG_LINE_WIDTH   = 3'd0;
   localparam logic [2:0] REG_LINE_BYTES   = 3'd1;
   localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd2;
   localparam logic [2:0] REG_POLARITY     = 3'd3;
   localparam logic [2:0] REG_THRESHOLD    = 3'd4;

   localparam logic [9:0]  RST_LINE_WIDTH   = 10'd512;
   localparam logic [6:0]  RST_LINE_BYTES   = 7'd64;
   localparam logic [15:0] RST_IMAGE_HEIGHT = 16'hFFFF;
   localparam logic        RST_POLARITY     = 1'b1;
   localparam logic [7:0]  RST_THRESHOLD    = 8'd128;

   localparam logic [2:0] WEIGHT_RIGHT = 3'd7;
   localparam logic [2:0] WEIGHT_BACK  = 3'd3;
   localparam logic [2:0] WEIGHT_DOWN  = 3'd5;
   localparam logic [2:0] WEIGHT_AHEAD = 3'd1;

   // Share of an error in sixteenths, truncated toward zero.
   function automatic logic signed [8:0] share(input logic signed [9:0] v,
                                               input logic [2:0] k);
      logic signed [13:0] p;
      logic signed [13:0] q;
      p = 14'(v) * $signed({11'd0, k});
      q = (p < 0) ? (p + 14'sd15) : p;
      return 9'(q >>> 4);
   endfunction

endpackage

/* hdl/serpentine_error_diffusion_dither.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serpentine error-diffusion dither
// Loads a line of gray pixels plus carried error, then walks it in
// alternating directions and sends it out as packed bytes.
// ----------------------------------------------------------------------------
// A pixel is taken and the carry store read in ST_LOAD, and the line store
// written in ST_LOAD2. The walk takes one pixel per cycle through the
// registered line store read, then ST_WEND and ST_WFIN; line_bytes bytes
// follow at full rate unless rsp_ready stalls. Reset clears control state
// and all MAX_WIDTH carry store entries, as after every image's last line.
module serpentine_error_diffusion_dither
   import sedd_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_gray_pixel,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_packed_byte,
   output logic        rsp_line_end,
   output logic        rsp_image_end,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int COL_BITS = $clog2(MAX_WIDTH);
   localparam int CNT_BITS = $clog2(MAX_WIDTH + 1);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_LOAD  = 3'd1;
   localparam logic [2:0] ST_LOAD2 = 3'd2;
   localparam logic [2:0] ST_WALK  = 3'd3;
   localparam logic [2:0] ST_WEND  = 3'd4;
   localparam logic [2:0] ST_WFIN  = 3'd5;
   localparam logic [2:0] ST_OUT   = 3'd6;

   typedef logic signed [VALUE_BITS-1:0] value_type;

   logic [9:0]  line_width_ff;
   logic [6:0]  line_bytes_ff;
   logic [15:0] image_height_ff;
   logic        polarity_ff;
   logic [7:0]  threshold_ff;

   logic [2:0]          state_ff, state_in;
   logic [CNT_BITS-1:0] col_ff, col_in;
   logic [CNT_BITS-1:0] n_ff, n_in;
   logic [COL_BITS-1:0] clr_ff, clr_in;
   logic [15:0]         row_ff, row_in;
   logic [5:0]          k_ff, k_in;
   logic [7:0]          pix_ff, pix_in;

   value_type line_mem  [MAX_WIDTH];
   value_type carry_mem [MAX_WIDTH];
   value_type store_rd_ff;
   value_type carry_rd_ff;
   logic [7:0] out_mem [OUT_BYTES_MAX];
   logic [7:0] ob_rd_ff;

   logic                s1_vld_ff, s1_vld_in;
   logic [COL_BITS-1:0] s1_j_ff, s1_j_in;
   logic                s1_first_ff, s1_first_in;
   value_type           sh7_ff, sh7_in;
   value_type           acc_cur_ff, acc_cur_in;
   value_type           acc_next_ff, acc_next_in;
   logic [7:0]          byte_acc_ff, byte_acc_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_lend_ff, rsp_lend_in;
   logic       rsp_iend_ff, rsp_iend_in;

   logic [CNT_BITS-1:0] w_eff;
   logic [6:0]          nb_eff;
   logic [15:0]         h_eff;
   logic                last_row;
   logic                ltr;
   logic [CNT_BITS-1:0] j_rd_cnt;
   logic [COL_BITS-1:0] j_rd;

   logic                 ls_we;
   logic [COL_BITS-1:0]  ls_addr;
   value_type            ls_wdata;
   logic                 cw_en;
   logic [COL_BITS-1:0]  cw_addr;
   value_type            cw_data;
   logic                    ob_we;
   logic [OB_ADDR_BITS-1:0] ob_addr;

   value_type          v_work;
   logic [7:0]         v_clamp;
   logic               white;
   logic signed [9:0]  v_err;
   value_type          s7, s5, s3, s1;
   logic               new_byte;
   logic [7:0]         byte_bits;
   logic               covered;
   logic [7:0]         out_byte;
   logic               cfg_wr;

   assign cfg_wr = psel & penable & pwrite;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff   <= RST_LINE_WIDTH;
         line_bytes_ff   <= RST_LINE_BYTES;
         image_height_ff <= RST_IMAGE_HEIGHT;
         polarity_ff     <= RST_POLARITY;
         threshold_ff    <= RST_THRESHOLD;
      end else if (cfg_wr) begin
         unique case (paddr[4:2])
            REG_LINE_WIDTH:   line_width_ff   <= pwdata[9:0];
            REG_LINE_BYTES:   line_bytes_ff   <= pwdata[6:0];
            REG_IMAGE_HEIGHT: image_height_ff <= pwdata[15:0];
            REG_POLARITY:     polarity_ff     <= pwdata[0];
            REG_THRESHOLD:    threshold_ff    <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[4:2])
         REG_LINE_WIDTH:   prdata = {22'd0, line_width_ff};
         REG_LINE_BYTES:   prdata = {25'd0, line_bytes_ff};
         REG_IMAGE_HEIGHT: prdata = {16'd0, image_height_ff};
         REG_POLARITY:     prdata = {31'd0, polarity_ff};
         REG_THRESHOLD:    prdata = {24'd0, threshold_ff};
         default:          prdata = 32'd0;
      endcase
   end

   always_comb begin
      if (line_width_ff == 10'd0) begin
         w_eff = CNT_BITS'(1);
      end else if (line_width_ff > 10'(MAX_WIDTH)) begin
         w_eff = CNT_BITS'(MAX_WIDTH);
      end else begin
         w_eff = CNT_BITS'(line_width_ff);
      end
      if (line_bytes_ff == 7'd0) begin
         nb_eff = 7'd1;
      end else if (line_bytes_ff > 7'(OUT_BYTES_MAX)) begin
         nb_eff = 7'(OUT_BYTES_MAX);
      end else begin
         nb_eff = line_bytes_ff;
      end
      h_eff = (image_height_ff == 16'd0) ? 16'd1 : image_height_ff;
   end

   assign last_row = ({1'b0, row_ff} + 17'd1) >= {1'b0, h_eff};
   assign ltr      = ~row_ff[0];
   assign j_rd_cnt = ltr ? n_ff : (w_eff - CNT_BITS'(1) - n_ff);
   assign j_rd     = j_rd_cnt[COL_BITS-1:0];
   assign ob_addr  = OB_ADDR_BITS'(s1_j_ff >> 3);

   // Walk datapath: stored value plus the 7/16 share of the previous pixel.
   always_comb begin
      v_work  = store_rd_ff + (s1_first_ff ? value_type'(0) : sh7_ff);
      if (v_work < 0) begin
         v_clamp = 8'd0;
      end else if (v_work > value_type'(255)) begin
         v_clamp = 8'd255;
      end else begin
         v_clamp = v_work[7:0];
      end
      white = v_clamp > threshold_ff;
      v_err = white ? ($signed({2'b00, v_clamp}) - 10'sd255)
                    : $signed({2'b00, v_clamp});
      s7 = value_type'(share(v_err, WEIGHT_RIGHT));
      s5 = value_type'(share(v_err, WEIGHT_DOWN));
      s3 = value_type'(share(v_err, WEIGHT_BACK));
      s1 = value_type'(share(v_err, WEIGHT_AHEAD));
      new_byte  = s1_first_ff |
                  (ltr ? (s1_j_ff[2:0] == 3'd0) : (s1_j_ff[2:0] == 3'd7));
      byte_bits = (new_byte ? 8'd0 : byte_acc_ff) |
                  ({7'd0, white} << (3'd7 - s1_j_ff[2:0]));
   end

   always_comb begin
      covered  = {1'b0, k_ff, 3'b000} < 10'(w_eff);
      out_byte = covered ? ob_rd_ff : 8'd0;
      if (!polarity_ff) begin
         out_byte = ~out_byte;
      end
   end

   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      n_in         = n_ff;
      clr_in       = clr_ff;
      row_in       = row_ff;
      k_in         = k_ff;
      pix_in       = pix_ff;
      s1_vld_in    = 1'b0;
      s1_j_in      = s1_j_ff;
      s1_first_in  = s1_first_ff;
      sh7_in       = sh7_ff;
      acc_cur_in   = acc_cur_ff;
      acc_next_in  = acc_next_ff;
      byte_acc_in  = byte_acc_ff;
      ob_we        = 1'b0;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_lend_in  = rsp_lend_ff;
      rsp_iend_in  = rsp_iend_ff;
      req_ready    = 1'b0;
      ls_we        = 1'b0;
      ls_addr      = j_rd;
      ls_wdata     = value_type'(0);
      cw_en        = 1'b0;
      cw_addr      = col_ff[COL_BITS-1:0];
      cw_data      = value_type'(0);

      if (s1_vld_ff) begin
         sh7_in      = s7;
         byte_acc_in = byte_bits;
         ob_we       = 1'b1;
         acc_cur_in  = (s1_first_ff ? value_type'(0) : acc_next_ff) + s5;
         acc_next_in = s1;
         if (!last_row && !s1_first_ff) begin
            cw_en   = 1'b1;
            cw_addr = ltr ? (s1_j_ff - COL_BITS'(1)) : (s1_j_ff + COL_BITS'(1));
            cw_data = acc_cur_ff + s3;
         end
      end

      unique case (state_ff)
         ST_CLEAR: begin
            cw_en   = 1'b1;
            cw_addr = clr_ff;
            clr_in  = clr_ff + COL_BITS'(1);
            if (clr_ff == COL_BITS'(MAX_WIDTH - 1)) begin
               clr_in   = '0;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               pix_in   = req_gray_pixel;
               state_in = ST_LOAD2;
            end
         end
         ST_LOAD2: begin
            ls_we    = 1'b1;
            ls_addr  = col_ff[COL_BITS-1:0];
            ls_wdata = value_type'({1'b0, pix_ff}) + carry_rd_ff;
            cw_en    = 1'b1;
            if (col_ff + CNT_BITS'(1) < w_eff) begin
               col_in   = col_ff + CNT_BITS'(1);
               state_in = ST_LOAD;
            end else begin
               col_in   = '0;
               n_in     = '0;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            s1_vld_in   = 1'b1;
            s1_j_in     = j_rd;
            s1_first_in = (n_ff == '0);
            n_in        = n_ff + CNT_BITS'(1);
            if (n_ff == w_eff - CNT_BITS'(1)) begin
               state_in = ST_WEND;
            end
         end
         ST_WEND: begin
            state_in = ST_WFIN;
         end
         ST_WFIN: begin
            if (!last_row) begin
               cw_en   = 1'b1;
               cw_addr = s1_j_ff;
               cw_data = acc_cur_ff;
            end
            k_in     = '0;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = out_byte;
               rsp_lend_in  = 1'b0;
               rsp_iend_in  = 1'b0;
               k_in         = k_ff + 6'd1;
               if ({1'b0, k_ff} == nb_eff - 7'd1) begin
                  rsp_lend_in = 1'b1;
                  rsp_iend_in = last_row;
                  if (last_row) begin
                     row_in   = '0;
                     state_in = ST_CLEAR;
                  end else begin
                     row_in   = row_ff + 16'd1;
                     state_in = ST_LOAD;
                  end
               end
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ls_we) begin
         line_mem[ls_addr] <= ls_wdata;
      end
      store_rd_ff <= line_mem[ls_addr];
   end

   always_ff @(posedge clock) begin
      if (cw_en) begin
         carry_mem[cw_addr] <= cw_data;
      end
      carry_rd_ff <= carry_mem[col_ff[COL_BITS-1:0]];
   end

   // The read address is k_in, the next k_ff, so that the data for k_ff is ready.
   always_ff @(posedge clock) begin
      if (ob_we) begin
         out_mem[ob_addr] <= byte_bits;
      end
      ob_rd_ff <= out_mem[k_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         col_ff       <= '0;
         n_ff         <= '0;
         clr_ff       <= '0;
         row_ff       <= '0;
         k_ff         <= '0;
         s1_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         n_ff         <= n_in;
         clr_ff       <= clr_in;
         row_ff       <= row_in;
         k_ff         <= k_in;
         s1_vld_ff    <= s1_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff      <= pix_in;
      s1_j_ff     <= s1_j_in;
      s1_first_ff <= s1_first_in;
      sh7_ff      <= sh7_in;
      acc_cur_ff  <= acc_cur_in;
      acc_next_ff <= acc_next_in;
      byte_acc_ff <= byte_acc_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_lend_ff <= rsp_lend_in;
      rsp_iend_ff <= rsp_iend_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_packed_byte = rsp_byte_ff;
   assign rsp_line_end    = rsp_lend_ff;
   assign rsp_image_end   = rsp_iend_ff;

   a_load_follows: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_LOAD2))
      else $error("pixel transfer not followed by store write");

   a_image_end_on_line_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_image_end) |-> rsp_line_end)
      else $error("image end without line end");

   a_walk_stage: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff |-> (state_ff == ST_WALK || state_ff == ST_WEND))
      else $error("walk stage active outside walk");

   a_no_load_in_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |=> !ls_we)
      else $error("line store written during walk");

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serpentine error-diffusion dither testbench
// Streams gray scanlines through the block under a series of register
// settings and checks every packed output byte against an in-bench model
// of the serpentine error diffusion, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb;
   import sedd_pkg::*;

   typedef struct packed {
      logic [7:0] packed_byte;
      logic       line_end;
      logic       image_end;
   } out_byte_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_gray_pixel;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_packed_byte;
   logic        rsp_line_end;
   logic        rsp_image_end;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [4:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   serpentine_error_diffusion_dither dut (.*);

   // Dither state mirrored in the bench.
   int        cfg_width = 512;
   int        cfg_bytes = 64;
   int        cfg_height = 65535;
   int        cfg_polarity = 1;
   int        cfg_threshold = 128;
   int        work_line[512];
   int        down_error[512];
   int        load_col = 0;
   int        image_row = 0;

   logic [7:0]   pixel_q[$];
   out_byte_type expected_bytes[$];
   int           errors = 0;
   int           pixels_queued = 0;
   bit           steady = 0;
   bit           req_fired = 0;
   int           send_gap = 0;
   int           stall_gap = 0;

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   function automatic int wrap_value(int x);
      logic signed [11:0] s;
      s = x[11:0];
      return int'(s);
   endfunction

   function automatic int error_share(int v, int k);
      int p;
      p = v * k;
      return (p < 0) ? -((-p) / 16) : p / 16;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic void add_line(int idx, int d);
      if (idx >= 0 && idx < 512) work_line[idx] = wrap_value(work_line[idx] + d);
   endfunction

   function automatic void add_down(int idx, int d);
      if (idx >= 0 && idx < 512) down_error[idx] = wrap_value(down_error[idx] + d);
   endfunction

   function automatic void dither_pixel(logic [7:0] gray);
      int w, nb, h, col, j, v, dir;
      bit last_row, ltr, first, lastpix;
      logic [7:0] bytes[64];
      out_byte_type ob;
      w = (cfg_width == 0) ? 1 : (cfg_width > 512 ? 512 : cfg_width);
      nb = (cfg_bytes == 0) ? 1 : (cfg_bytes > 64 ? 64 : cfg_bytes);
      h = (cfg_height == 0) ? 1 : cfg_height;
      col = load_col;
      if (col < 512) begin
         work_line[col] = wrap_value(int'(gray) + down_error[col]);
         down_error[col] = 0;
      end
      if (col + 1 < w) begin
         load_col = col + 1;
         return;
      end
      load_col = 0;
      last_row = (image_row + 1 >= h);
      ltr = (image_row % 2) == 0;
      dir = ltr ? 1 : -1;
      foreach (bytes[k]) bytes[k] = 8'h00;
      for (int n = 0; n < w; n++) begin
         j = ltr ? n : (w - 1 - n);
         first = (n == 0);
         lastpix = (n == w - 1);
         v = work_line[j];
         if (v < 0) v = 0;
         else if (v > 255) v = 255;
         if (v > cfg_threshold) begin
            if ((j >> 3) < nb) bytes[j >> 3] |= 8'h80 >> (j & 7);
            v -= 255;
         end
         if (!lastpix) add_line(j + dir, error_share(v, 7));
         if (!last_row) begin
            if (!first) add_down(j - dir, error_share(v, 3));
            add_down(j, error_share(v, 5));
            if (!lastpix) add_down(j + dir, error_share(v, 1));
         end
      end
      for (int k = 0; k < nb; k++) begin
         ob.packed_byte = (cfg_polarity == 0) ? ~bytes[k] : bytes[k];
         ob.line_end = (k == nb - 1);
         ob.image_end = (k == nb - 1) && last_row;
         expected_bytes.push_back(ob);
      end
      if (last_row) begin
         image_row = 0;
         foreach (down_error[k]) down_error[k] = 0;
      end else begin
         image_row = (image_row + 1) & 16'hFFFF;
      end
   endfunction

   // Input driver and rsp_ready stall generator.
   always @(negedge clock) begin
      bit hold;
      hold = req_valid && !req_fired;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!hold) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pixel_q.size() > 0) begin
            req_gray_pixel <= pixel_q.pop_front();
            req_valid <= 1'b1;
            send_gap <= pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
      if (stall_gap > 0) begin
         stall_gap <= stall_gap - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         stall_gap <= pick_gap();
      end
   end

   // Monitor and checker.
   always @(posedge clock) begin
      out_byte_type ob;
      req_fired <= !reset && req_valid && req_ready;
      if (!reset && req_valid && req_ready) dither_pixel(req_gray_pixel);
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_bytes.size() == 0) begin
            $display("%0t: unexpected transfer byte=%h", $time, rsp_packed_byte);
            errors++;
         end else begin
            ob = expected_bytes.pop_front();
            if (ob.packed_byte !== rsp_packed_byte) begin
               $display("%0t: packed_byte expected %h actual %h", $time,
                        ob.packed_byte, rsp_packed_byte);
               errors++;
            end
            if (ob.line_end !== rsp_line_end) begin
               $display("%0t: line_end expected %b actual %b", $time,
                        ob.line_end, rsp_line_end);
               errors++;
            end
            if (ob.image_end !== rsp_image_end) begin
               $display("%0t: image_end expected %b actual %b", $time,
                        ob.image_end, rsp_image_end);
               errors++;
            end
         end
      end
   end

   task automatic write_reg(logic [2:0] idx, int value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_LINE_WIDTH:   cfg_width = value & 10'h3FF;
         REG_LINE_BYTES:   cfg_bytes = value & 7'h7F;
         REG_IMAGE_HEIGHT: cfg_height = value & 16'hFFFF;
         REG_POLARITY:     cfg_polarity = value & 1;
         REG_THRESHOLD:    cfg_threshold = value & 8'hFF;
         default: ;
      endcase
   endtask

   task automatic configure(int w, int nb, int h, int pol, int thr);
      write_reg(REG_LINE_WIDTH, w);
      write_reg(REG_LINE_BYTES, nb);
      write_reg(REG_IMAGE_HEIGHT, h);
      write_reg(REG_POLARITY, pol);
      write_reg(REG_THRESHOLD, thr);
   endtask

   task automatic drain();
      wait (pixel_q.size() == 0 && !req_valid && expected_bytes.size() == 0);
      repeat (600) @(posedge clock);
   endtask

   function automatic logic [7:0] random_pixel();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 8'd0;
      if (r == 1) return 8'd255;
      return $urandom_range(0, 255);
   endfunction

   task automatic random_phase(int w, int lines);
      int eff;
      eff = (w == 0) ? 1 : (w > 512 ? 512 : w);
      for (int i = 0; i < eff * lines; i++) begin
         pixel_q.push_back(random_pixel());
         pixels_queued++;
      end
      drain();
   endtask

   initial begin
      logic [7:0] edge_pixels[8] = '{8'd0, 8'd255, 8'd128, 8'd127,
                                     8'd1, 8'd254, 8'd0, 8'd255};
      int w, nb, h, thr, phase, eff, lines;
      reset = 1'b1;
      req_valid = 1'b0;
      req_gray_pixel = 8'd0;
      rsp_ready = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (600) @(posedge clock);

      configure(8, 1, 2, 0, 0);
      for (int i = 0; i < 16; i++) pixel_q.push_back(edge_pixels[i % 8]);
      drain();
      configure(0, 0, 0, 1, 255);
      pixel_q.push_back(8'd255);
      pixel_q.push_back(8'd0);
      drain();
      configure(3, 127, 3, 0, 128);
      for (int i = 0; i < 6; i++) pixel_q.push_back(i[0] ? 8'd255 : 8'd200);
      drain();

      phase = 0;
      while (pixels_queued < 336) begin
         steady = (phase % 4) == 3;
         w = $urandom_range(0, 99);
         if (w < 85) w = $urandom_range(1, 20);
         else if (w < 92) w = 0;
         else w = $urandom_range(21, 100);
         nb = (w + 7) / 8 + $urandom_range(0, 2);
         if ($urandom_range(0, 3) == 0) nb = $urandom_range(0, 127);
         h = ($urandom_range(0, 5) == 0) ? 65535 : $urandom_range(0, 4);
         thr = $urandom_range(0, 9);
         thr = (thr == 0) ? 0 : (thr == 1 ? 255 : $urandom_range(0, 255));
         configure(w, nb, h, $urandom_range(0, 1), thr);
         eff = (w == 0) ? 1 : w;
         lines = $urandom_range(1, 4);
         while (lines > 1 && pixels_queued + eff * lines > 350) lines--;
         random_phase(w, lines);
         phase++;
      end

      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
